// ----- design/gbn_pkg.sv -----
// Shared types, codes and constants of the go-back-N link controller.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int SEQ_BITS_DEF = 3;

    localparam int ACTION_W   = 3;
    localparam int LEN_W      = 9;
    localparam int KIND_W     = 2;
    localparam int SEQ_W      = 3;
    localparam int CMD_W      = 4;
    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 4;

    localparam int MAX_RESULTS = 12;
    localparam int RES_CNT_W   = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    localparam logic [LEN_W-1:0]   MIN_GOOD_LEN     = 9'd6;
    localparam logic [LEN_W-1:0]   HDR_CRC_LEN      = 9'd7;
    localparam logic [VALUE_W-1:0] DATA_TIMEOUT_RST = 16'd2000;
    localparam logic [VALUE_W-1:0] ACK_TIMEOUT_RST  = 16'd1100;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 2'd1;

    localparam logic [ACTION_W-1:0] ACT_NET_READY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PHY_READY = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FRAME     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DATA_TO   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ACK_TO    = 3'd4;

    localparam logic [KIND_W-1:0] FRM_DATA = 2'd0;
    localparam logic [KIND_W-1:0] FRM_NAK  = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND_DATA  = 4'd0,
        CMD_SEND_ACK   = 4'd1,
        CMD_SEND_NAK   = 4'd2,
        CMD_DELIVER    = 4'd3,
        CMD_START_DATA = 4'd4,
        CMD_STOP_DATA  = 4'd5,
        CMD_START_ACK  = 4'd6,
        CMD_STOP_ACK   = 4'd7,
        CMD_NET_ENABLE = 4'd8
    } gbn_cmd_t;

    typedef enum logic [3:0] {
        EV_NET_READY,
        EV_PHY_READY,
        EV_RX_BAD,
        EV_RX_DATA,
        EV_RX_NAK,
        EV_RX_OTHER,
        EV_DATA_TO,
        EV_ACK_TO,
        EV_NOP
    } gbn_ev_kind_t;

    typedef struct packed {
        gbn_ev_kind_t     kind;
        logic [SEQ_W-1:0] rseq;
        logic [SEQ_W-1:0] rack;
        logic [LEN_W-1:0] dlen;
    } gbn_event_t;

    typedef struct packed {
        logic [VALUE_W-1:0] data_ms;
        logic [VALUE_W-1:0] ack_ms;
    } gbn_timeouts_t;

    typedef struct packed {
        gbn_cmd_t           cmd;
        logic [SEQ_W-1:0]   seq_no;
        logic [SEQ_W-1:0]   ack_no;
        logic [VALUE_W-1:0] value;
        logic               last;
    } gbn_result_t;

endpackage

`default_nettype wire

// ----- design/gbn_front.sv -----
// Input side: accepts event words and classifies them for the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module gbn_front
    import gbn_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // frame_len, rx_seq, rx_ack, zero pad
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // action, crc_good, rx_kind
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    output logic                 push,
    output gbn_event_t           push_data,
    input  logic                 full
);

    logic [ACTION_W-1:0] action;
    logic                crc_good;
    logic [KIND_W-1:0]   rx_kind;
    logic [LEN_W-1:0]    frame_len;
    logic                good;

    assign action     = s_axis_tuser[2:0];
    assign crc_good   = s_axis_tuser[3];
    assign rx_kind    = s_axis_tuser[5:4];
    assign frame_len  = s_axis_tdata[8:0];

    assign good          = crc_good && (frame_len >= MIN_GOOD_LEN);
    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    always_comb
    begin
        push_data.rseq = s_axis_tdata[11:9];
        push_data.rack = s_axis_tdata[14:12];
        push_data.dlen = (frame_len > HDR_CRC_LEN) ? (frame_len - HDR_CRC_LEN) : '0;
        case (action)
            ACT_NET_READY: push_data.kind = EV_NET_READY;
            ACT_PHY_READY: push_data.kind = EV_PHY_READY;
            ACT_FRAME:
            begin
                if (!good)
                begin
                    push_data.kind = EV_RX_BAD;
                end
                else
                begin
                    case (rx_kind)
                        FRM_DATA: push_data.kind = EV_RX_DATA;
                        FRM_NAK:  push_data.kind = EV_RX_NAK;
                        default:  push_data.kind = EV_RX_OTHER;
                    endcase
                end
            end
            ACT_DATA_TO:   push_data.kind = EV_DATA_TO;
            ACT_ACK_TO:    push_data.kind = EV_ACK_TO;
            default:       push_data.kind = EV_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/gbn_queue.sv -----
// Short event queue between the classifier and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module gbn_queue
    import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gbn_event_t push_data,
    output logic       full,
    input  logic       pop,
    output gbn_event_t head,
    output logic       not_empty
);

    gbn_event_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/gbn_back.sv -----
// Protocol sequencer: window state, command generation and output register.
`timescale 1ns / 1ps
`default_nettype none

module gbn_back
    import gbn_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gbn_event_t    q_head,
    output logic          q_pop,
    input  gbn_timeouts_t tmo,
    output logic          out_valid,
    input  logic          out_ready,
    output gbn_result_t   out_word
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_DISPATCH   = 10'b0000000010,
        S_STOP_ACK   = 10'b0000000100,
        S_SEND       = 10'b0000001000,
        S_START_DATA = 10'b0000010000,
        S_DELIVER    = 10'b0000100000,
        S_START_ACK  = 10'b0001000000,
        S_ACK_LOOP   = 10'b0010000000,
        S_WIN_CHECK  = 10'b0100000000,
        S_NET_EN     = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        FK_DATA,
        FK_ACK,
        FK_NAK
    } frame_sel_t;

    typedef enum logic [1:0] {
        RET_WIN,
        RET_LOOP,
        RET_NET
    } ret_sel_t;

    localparam logic [SEQ_BITS-1:0] WINDOW  = '1;
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

    state_t                state_reg, state_next;
    frame_sel_t            fk_reg, fk_next;
    ret_sel_t              ret_reg, ret_next;
    gbn_event_t            ev_reg, ev_next;
    logic [SEQ_BITS-1:0]   upper_reg, upper_next;
    logic [SEQ_BITS-1:0]   lower_reg, lower_next;
    logic [SEQ_BITS-1:0]   rexp_reg, rexp_next;
    logic [SEQ_BITS-1:0]   buf_reg, buf_next;
    logic                  phy_reg, phy_next;
    logic                  nak_ok_reg, nak_ok_next;
    logic                  net_val_reg, net_val_next;
    logic [RES_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    gbn_result_t           out_reg, out_next;

    logic [SEQ_BITS-1:0]   rseq;
    logic [SEQ_BITS-1:0]   rack;
    logic [SEQ_BITS-1:0]   ackv;
    logic [SEQ_BITS-1:0]   win_sum;
    logic                  in_win;
    logic                  can_emit;
    logic                  emit;
    logic                  store;
    gbn_result_t           emit_res;
    state_t                ret_state;

    assign rseq     = SEQ_BITS'(ev_reg.rseq);
    assign rack     = SEQ_BITS'(ev_reg.rack);
    assign ackv     = rexp_reg + WINDOW;
    assign win_sum  = lower_reg + buf_reg;
    assign in_win   = ((lower_reg <= rack) && (rack < upper_reg))
                   || ((upper_reg < lower_reg) && (rack < upper_reg))
                   || ((upper_reg < lower_reg) && (lower_reg <= rack));
    assign can_emit = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        case (ret_reg)
            RET_LOOP: ret_state = S_ACK_LOOP;
            RET_NET:  ret_state = S_NET_EN;
            default:  ret_state = S_WIN_CHECK;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        fk_next      = fk_reg;
        ret_next     = ret_reg;
        ev_next      = ev_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        rexp_next    = rexp_reg;
        buf_next     = buf_reg;
        phy_next     = phy_reg;
        nak_ok_next  = nak_ok_reg;
        net_val_next = net_val_reg;
        cnt_next     = cnt_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_res     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ev_next    = q_head;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next   = '0;
                state_next = S_WIN_CHECK;
                case (ev_reg.kind)
                    EV_NET_READY:
                    begin
                        if (buf_reg != WINDOW)
                        begin
                            buf_next   = buf_reg + SEQ_ONE;
                            fk_next    = FK_DATA;
                            ret_next   = RET_WIN;
                            state_next = S_STOP_ACK;
                        end
                    end
                    EV_PHY_READY: phy_next = 1'b1;
                    EV_RX_BAD:
                    begin
                        if (nak_ok_reg)
                        begin
                            fk_next    = FK_NAK;
                            ret_next   = RET_WIN;
                            state_next = S_STOP_ACK;
                        end
                    end
                    EV_RX_DATA:
                    begin
                        if (rseq == rexp_reg)
                        begin
                            state_next = S_DELIVER;
                        end
                        else if (nak_ok_reg)
                        begin
                            fk_next    = FK_NAK;
                            ret_next   = RET_LOOP;
                            state_next = S_STOP_ACK;
                        end
                        else
                        begin
                            state_next = S_ACK_LOOP;
                        end
                    end
                    EV_RX_NAK:
                    begin
                        if ((rack + SEQ_ONE) == lower_reg)
                        begin
                            upper_next = lower_reg;
                        end
                        state_next = S_ACK_LOOP;
                    end
                    EV_RX_OTHER: state_next = S_ACK_LOOP;
                    EV_DATA_TO:  upper_next = lower_reg;
                    EV_ACK_TO:
                    begin
                        fk_next    = FK_ACK;
                        ret_next   = RET_WIN;
                        state_next = S_STOP_ACK;
                    end
                    default: state_next = S_WIN_CHECK;
                endcase
            end
            S_STOP_ACK:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    emit_res.cmd = CMD_STOP_ACK;
                    state_next   = S_SEND;
                end
            end
            S_SEND:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    phy_next        = 1'b0;
                    emit_res.ack_no = SEQ_W'(ackv);
                    case (fk_reg)
                        FK_DATA:
                        begin
                            emit_res.cmd    = CMD_SEND_DATA;
                            emit_res.seq_no = SEQ_W'(upper_reg);
                            state_next      = S_START_DATA;
                        end
                        FK_ACK:
                        begin
                            emit_res.cmd = CMD_SEND_ACK;
                            state_next   = ret_state;
                        end
                        default:
                        begin
                            nak_ok_next  = 1'b0;
                            emit_res.cmd = CMD_SEND_NAK;
                            state_next   = ret_state;
                        end
                    endcase
                end
            end
            S_START_DATA:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_res.cmd    = CMD_START_DATA;
                    emit_res.seq_no = SEQ_W'(upper_reg);
                    emit_res.value  = tmo.data_ms;
                    upper_next      = upper_reg + SEQ_ONE;
                    state_next      = ret_state;
                end
            end
            S_DELIVER:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_res.cmd   = CMD_DELIVER;
                    emit_res.value = VALUE_W'(ev_reg.dlen);
                    rexp_next      = rexp_reg + SEQ_ONE;
                    nak_ok_next    = 1'b1;
                    state_next     = S_START_ACK;
                end
            end
            S_START_ACK:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_res.cmd   = CMD_START_ACK;
                    emit_res.value = tmo.ack_ms;
                    state_next     = S_ACK_LOOP;
                end
            end
            S_ACK_LOOP:
            begin
                if (!in_win)
                begin
                    state_next = S_WIN_CHECK;
                end
                else if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_res.cmd    = CMD_STOP_DATA;
                    emit_res.seq_no = SEQ_W'(lower_reg);
                    buf_next        = (buf_reg == '0) ? '0 : buf_reg - SEQ_ONE;
                    lower_next      = lower_reg + SEQ_ONE;
                end
            end
            S_WIN_CHECK:
            begin
                if (win_sum == upper_reg)
                begin
                    net_val_next = (buf_reg != WINDOW) && phy_reg;
                    state_next   = S_NET_EN;
                end
                else
                begin
                    net_val_next = 1'b0;
                    fk_next      = FK_DATA;
                    ret_next     = RET_NET;
                    state_next   = S_STOP_ACK;
                end
            end
            S_NET_EN:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_res.cmd   = CMD_NET_ENABLE;
                    emit_res.value = VALUE_W'(net_val_reg);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        emit_res.last = (state_reg == S_NET_EN)
                     || (cnt_reg == RES_CNT_W'(MAX_RESULTS - 1));
        store = emit && (cnt_reg < RES_CNT_W'(MAX_RESULTS));

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (store)
        begin
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            out_next       = emit_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            upper_reg     <= '0;
            lower_reg     <= '0;
            rexp_reg      <= '0;
            buf_reg       <= '0;
            phy_reg       <= 1'b0;
            nak_ok_reg    <= 1'b1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            rexp_reg      <= rexp_next;
            buf_reg       <= buf_next;
            phy_reg       <= phy_next;
            nak_ok_reg    <= nak_ok_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fk_reg      <= fk_next;
        ret_reg     <= ret_next;
        ev_reg      <= ev_next;
        net_val_reg <= net_val_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

// ----- design/go_back_n_link_controller_core.sv -----
// Top level of the go-back-N link controller: config registers, front, queue, sequencer.
// Flow: an accepted word is written into the queue; the idle sequencer pops it, dispatches
// it, then emits its command words, with a step each for ack-loop exit and window check.
// The sequencer takes a new event only after its last word and emits one word per cycle
// while the output is not stalled; the two-entry queue lets input words in while it works.
// Reset: asynchronous; clears window state and queue, timeouts return to 2000 and 1100.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_link_controller_core
    import gbn_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_len, rx_seq, rx_ack, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action, crc_good, rx_kind
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // seq_no, ack_no, value, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // command
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VALUE_W-1:0]    cfg_data
);

    gbn_timeouts_t tmo_reg, tmo_next;
    logic          push;
    gbn_event_t    push_data;
    logic          full;
    logic          pop;
    gbn_event_t    head;
    logic          not_empty;
    gbn_result_t   res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tmo_next = tmo_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DATA_TIMEOUT: tmo_next.data_ms = cfg_data;
                REG_ACK_TIMEOUT:  tmo_next.ack_ms  = cfg_data;
                default:          tmo_next = tmo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg.data_ms <= DATA_TIMEOUT_RST;
            tmo_reg.ack_ms  <= ACK_TIMEOUT_RST;
        end
        else
        begin
            tmo_reg <= tmo_next;
        end
    end

    gbn_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    gbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    gbn_back #(
        .SEQ_BITS (SEQ_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_head    (head),
        .q_pop     (pop),
        .tmo       (tmo_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (res)
    );

    assign m_axis_tdata = {2'b00, res.value, res.ack_no, res.seq_no};
    assign m_axis_tuser = res.cmd;
    assign m_axis_tlast = res.last;

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= CMD_NET_ENABLE))
        else $error("command code out of range");

    a_enable_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == CMD_NET_ENABLE)) |-> m_axis_tlast)
        else $error("network enable word not marked last");

    a_enable_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == CMD_NET_ENABLE))
            |-> ((m_axis_tdata[21:7] == '0) && (m_axis_tdata[5:0] == '0)))
        else $error("network enable word carries stray fields");

    a_seq_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] != '0))
            |-> ((m_axis_tuser == CMD_SEND_DATA) || (m_axis_tuser == CMD_START_DATA)
              || (m_axis_tuser == CMD_STOP_DATA)))
        else $error("sequence number on a non-data command");

endmodule

`default_nettype wire

// ----- sim/tb_go_back_n_link_controller_core.sv -----
// Self-checking stream testbench for the go-back-N link controller core.
`timescale 1ns / 1ps

module tb_go_back_n_link_controller_core;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                crc_good;
        logic [LEN_W-1:0]    frame_len;
        logic [KIND_W-1:0]   rx_kind;
        logic [SEQ_W-1:0]    rx_seq;
        logic [SEQ_W-1:0]    rx_ack;
    } link_event_t;

    localparam logic [KIND_W-1:0] FRM_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] FRM_OTHER = 2'd3;
    localparam logic [SEQ_W-1:0]  WIN_SIZE  = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [VALUE_W-1:0]    cfg_data = '0;

    link_event_t event_q[$];
    gbn_result_t cmd_q[$];
    gbn_result_t cmd_batch[$];

    int issued = 0;
    int accepted = 0;
    int errors = 0;
    int cycle_cnt = 0;

    // predictor state
    logic [SEQ_W-1:0]   win_hi;
    logic [SEQ_W-1:0]   win_lo;
    logic [SEQ_W-1:0]   rx_next;
    logic [SEQ_W-1:0]   n_buf;
    logic               phy_rdy;
    logic               nak_ok;
    logic [VALUE_W-1:0] data_ms;
    logic [VALUE_W-1:0] ack_ms;

    // stimulus-side view of the peer
    logic [SEQ_W-1:0] gen_tx_cnt = '0;
    logic [SEQ_W-1:0] gen_rx_seq = '0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_cyc = 0;

    go_back_n_link_controller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void post_cmd(gbn_cmd_t cmd, logic [SEQ_W-1:0] seq,
                                     logic [SEQ_W-1:0] ack, logic [VALUE_W-1:0] val);
        gbn_result_t r;
        if (cmd_batch.size() < MAX_RESULTS)
        begin
            r.cmd    = cmd;
            r.seq_no = seq;
            r.ack_no = ack;
            r.value  = val;
            r.last   = 1'b0;
            cmd_batch.push_back(r);
        end
    endfunction

    function automatic logic seq_between(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                         logic [SEQ_W-1:0] c);
        return (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
    endfunction

    function automatic void tx_frame(gbn_cmd_t kind, logic [SEQ_W-1:0] nr);
        logic [SEQ_W-1:0] ackv;
        ackv = rx_next - 3'd1;
        post_cmd(CMD_STOP_ACK, '0, '0, '0);
        if (kind == CMD_SEND_DATA)
        begin
            post_cmd(CMD_SEND_DATA, nr, ackv, '0);
            post_cmd(CMD_START_DATA, nr, '0, data_ms);
        end
        else if (kind == CMD_SEND_ACK)
        begin
            post_cmd(CMD_SEND_ACK, '0, ackv, '0);
        end
        else
        begin
            nak_ok = 1'b0;
            post_cmd(CMD_SEND_NAK, '0, ackv, '0);
        end
        phy_rdy = 1'b0;
    endfunction

    function automatic void rx_frame(link_event_t ev);
        logic [SEQ_W-1:0] ack_nxt;
        logic [LEN_W-1:0] dlen;
        if (ev.frame_len < MIN_GOOD_LEN || !ev.crc_good)
        begin
            if (nak_ok)
                tx_frame(CMD_SEND_NAK, '0);
            return;
        end
        if (ev.rx_kind == FRM_DATA)
        begin
            if (ev.rx_seq == rx_next)
            begin
                dlen = (ev.frame_len > HDR_CRC_LEN) ? ev.frame_len - HDR_CRC_LEN : '0;
                post_cmd(CMD_DELIVER, '0, '0, VALUE_W'(dlen));
                rx_next = rx_next + 3'd1;
                nak_ok = 1'b1;
                post_cmd(CMD_START_ACK, '0, '0, ack_ms);
            end
            else if (nak_ok)
            begin
                tx_frame(CMD_SEND_NAK, '0);
            end
        end
        ack_nxt = ev.rx_ack + 3'd1;
        if (ev.rx_kind == FRM_NAK && ack_nxt == win_lo)
            win_hi = win_lo;
        while (seq_between(win_lo, ev.rx_ack, win_hi))
        begin
            if (n_buf > 0)
                n_buf = n_buf - 3'd1;
            post_cmd(CMD_STOP_DATA, win_lo, '0, '0);
            win_lo = win_lo + 3'd1;
        end
    endfunction

    function automatic void link_model_step(link_event_t ev);
        logic [SEQ_W-1:0] edge_sum;
        cmd_batch.delete();
        case (ev.action)
            ACT_NET_READY:
            begin
                if (n_buf < WIN_SIZE)
                begin
                    n_buf = n_buf + 3'd1;
                    tx_frame(CMD_SEND_DATA, win_hi);
                    win_hi = win_hi + 3'd1;
                end
            end
            ACT_PHY_READY: phy_rdy = 1'b1;
            ACT_FRAME:     rx_frame(ev);
            ACT_DATA_TO:   win_hi = win_lo;
            ACT_ACK_TO:    tx_frame(CMD_SEND_ACK, '0);
            default:       ;
        endcase
        edge_sum = win_lo + n_buf;
        if (edge_sum == win_hi)
        begin
            post_cmd(CMD_NET_ENABLE, '0, '0, {15'd0, (n_buf < WIN_SIZE) && phy_rdy});
        end
        else
        begin
            tx_frame(CMD_SEND_DATA, win_hi);
            win_hi = win_hi + 3'd1;
            post_cmd(CMD_NET_ENABLE, '0, '0, '0);
        end
        if (cmd_batch.size() > 0)
            cmd_batch[cmd_batch.size()-1].last = 1'b1;
        foreach (cmd_batch[i])
            cmd_q.push_back(cmd_batch[i]);
    endfunction

    function automatic void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // predict on input words, check output words
    always @(posedge clk)
    begin
        link_event_t ev;
        gbn_result_t exp_r;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            ev.action     = s_axis_tuser[2:0];
            ev.crc_good   = s_axis_tuser[3];
            ev.rx_kind    = s_axis_tuser[5:4];
            ev.frame_len  = s_axis_tdata[8:0];
            ev.rx_seq     = s_axis_tdata[11:9];
            ev.rx_ack     = s_axis_tdata[14:12];
            link_model_step(ev);
            accepted++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cmd_q.size() == 0)
            begin
                $error("unexpected output word: command %0d", m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_r = cmd_q.pop_front();
                cmp_field("command", exp_r.cmd, m_axis_tuser[3:0]);
                cmp_field("seq_no", exp_r.seq_no, m_axis_tdata[2:0]);
                cmp_field("ack_no", exp_r.ack_no, m_axis_tdata[5:3]);
                cmp_field("value", exp_r.value, m_axis_tdata[21:6]);
                cmp_field("last", exp_r.last, m_axis_tlast);
            end
        end
    end

    // input driver: bursts and gaps
    always @(negedge clk)
    begin
        link_event_t ev;
        if (rst_n && issued == accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                ev = event_q.pop_front();
                s_axis_tdata  <= {1'b0, ev.rx_ack, ev.rx_seq, ev.frame_len};
                s_axis_tuser  <= {ev.rx_kind, ev.crc_good, ev.action};
                s_axis_tvalid <= 1'b1;
                issued++;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output stall pattern
    always @(negedge clk)
    begin
        rx_cyc++;
        if (rx_cyc % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ((rx_cyc % 8) >= 3);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_DATA_TIMEOUT)
            data_ms = val;
        else
            ack_ms = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_event(input logic [ACTION_W-1:0] act, input logic crc,
                             input logic [LEN_W-1:0] len, input logic [KIND_W-1:0] kind,
                             input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] ack);
        link_event_t ev;
        ev.action     = act;
        ev.crc_good   = crc;
        ev.frame_len  = len;
        ev.rx_kind    = kind;
        ev.rx_seq     = seq;
        ev.rx_ack     = ack;
        event_q.push_back(ev);
    endtask

    function automatic link_event_t rand_event();
        link_event_t ev;
        int pick;
        ev.action     = ACT_FRAME;
        ev.crc_good   = ($urandom_range(0, 7) != 0);
        ev.frame_len  = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(6, 200));
        ev.rx_kind    = 2'($urandom_range(0, 3));
        ev.rx_seq     = 3'($urandom_range(0, 7));
        ev.rx_ack     = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            ev.action = ACT_NET_READY;
            gen_tx_cnt = gen_tx_cnt + 3'd1;
        end
        else if (pick < 45)
        begin
            ev.action = ACT_PHY_READY;
        end
        else if (pick < 85)
        begin
            pick = $urandom_range(0, 9);
            ev.rx_kind = (pick < 5) ? FRM_DATA : (pick < 7) ? FRM_ACK
                       : (pick < 9) ? FRM_NAK : FRM_OTHER;
            if ($urandom_range(0, 3) != 0)
            begin
                ev.rx_seq = gen_rx_seq;
                ev.rx_ack = gen_tx_cnt - 3'($urandom_range(1, 3));
            end
            if (ev.rx_kind == FRM_DATA && ev.rx_seq == gen_rx_seq)
                gen_rx_seq = gen_rx_seq + 3'd1;
        end
        else if (pick < 92)
        begin
            ev.action = ACT_DATA_TO;
        end
        else if (pick < 98)
        begin
            ev.action = ACT_ACK_TO;
        end
        else
        begin
            ev.action = 3'($urandom_range(5, 7));
        end
        return ev;
    endfunction

    task automatic wait_idle();
        while (event_q.size() != 0 || issued != accepted || cmd_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        win_hi  = '0;
        win_lo  = '0;
        rx_next = '0;
        n_buf   = '0;
        phy_rdy = 1'b0;
        nak_ok  = 1'b1;
        data_ms = DATA_TIMEOUT_RST;
        ack_ms  = ACK_TIMEOUT_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(REG_DATA_TIMEOUT, 16'd0);
                    write_reg(REG_ACK_TIMEOUT, 16'd0);
                end
                2:
                begin
                    write_reg(REG_DATA_TIMEOUT, 16'hFFFF);
                    write_reg(REG_ACK_TIMEOUT, 16'hFFFF);
                end
                3:
                begin
                    write_reg(REG_ACK_TIMEOUT, 16'($urandom));
                    write_reg(REG_DATA_TIMEOUT, 16'($urandom));
                end
                4:
                begin
                    write_reg(REG_DATA_TIMEOUT, 16'd1);
                    write_reg(REG_ACK_TIMEOUT, 16'hFFFE);
                end
                default: ;
            endcase
            if (ph == 0)
            begin
                add_event(ACT_PHY_READY, 1'b1, 9'd0, FRM_DATA, 3'd0, 3'd0);
                // fill the window; the eighth is dropped with the buffer full
                repeat (8) add_event(ACT_NET_READY, 1'b0, 9'd0, FRM_DATA, 3'd7, 3'd7);
                add_event(ACT_FRAME, 1'b1, 9'd6, FRM_ACK, 3'd7, 3'd2);
                add_event(ACT_FRAME, 1'b1, 9'd511, FRM_DATA, 3'd0, 3'd7);
                add_event(ACT_FRAME, 1'b1, 9'd6, FRM_DATA, 3'd1, 3'd0);
                add_event(ACT_FRAME, 1'b1, 9'd7, FRM_DATA, 3'd2, 3'd0);
                add_event(ACT_FRAME, 1'b1, 9'd40, FRM_DATA, 3'd5, 3'd0);
                add_event(ACT_FRAME, 1'b1, 9'd40, FRM_DATA, 3'd6, 3'd0);
                add_event(ACT_FRAME, 1'b0, 9'd100, FRM_DATA, 3'd3, 3'd0);
                add_event(ACT_FRAME, 1'b1, 9'd8, FRM_DATA, 3'd3, 3'd7);
                add_event(ACT_FRAME, 1'b1, 9'd5, FRM_DATA, 3'd4, 3'd0);
                add_event(ACT_FRAME, 1'b0, 9'd0, FRM_OTHER, 3'd0, 3'd0);
                add_event(ACT_FRAME, 1'b1, 9'd10, FRM_NAK, 3'd7, 3'd2);
                add_event(ACT_FRAME, 1'b1, 9'd20, FRM_OTHER, 3'd7, 3'd7);
                add_event(ACT_DATA_TO, 1'b1, 9'd511, FRM_OTHER, 3'd7, 3'd7);
                add_event(ACT_ACK_TO, 1'b0, 9'd0, FRM_DATA, 3'd0, 3'd0);
                add_event(3'd5, 1'b1, 9'd0, FRM_DATA, 3'd0, 3'd0);
                add_event(3'd6, 1'b0, 9'd0, FRM_DATA, 3'd0, 3'd0);
                add_event(3'd7, 1'b1, 9'd511, FRM_OTHER, 3'd7, 3'd7);
            end
            n = (ph == 0) ? 60 : 100;
            repeat (n) event_q.push_back(rand_event());
            // hold off until every command of this phase is out
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (cmd_q.size() != 0)
        begin
            $error("%0d expected words never arrived", cmd_q.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
